>>> src/scp_pkg.sv
// Shared types for the second-chance page replacement block.
// Controller state encoding and the command/status bundles between
// scp_ctrl and scp_dp. No dependencies.
`default_nettype none

package scp_pkg;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOOKUP = 4'b0010,
      ST_SWEEP  = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   typedef struct packed {
      logic accept;   // capture request, latch frame count
      logic lookup;   // parallel tag compare
      logic sweep;    // one hand step
      logic update;   // write frame state, load response
   } cmd_type;

   typedef struct packed {
      logic match_any;   // valid during lookup
      logic sweep_done;  // valid during sweep
   } sts_type;

   localparam int unsigned CFG_BITS = 4;
   localparam int unsigned IDX_OUT_BITS = 3;
   localparam int unsigned PAGE_OUT_BITS = 16;
   localparam int unsigned COUNT_BITS = 32;

endpackage

`default_nettype wire

>>> src/second_chance_page_replacement.sv
// Clock (second-chance) page replacement, one page request per start.
// A hit goes from lookup straight to update; a miss sweeps first, clearing k
// (0..frames_in_use) set reference bits with the hand, one per cycle, before its
// update. busy drops in the strobe cycle, so a new request may start in that cycle.
// Reset (synchronous): frames empty, bits and count zero, frames_in_use = FRAMES.
`default_nettype none

module second_chance_page_replacement #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [15:0]                   req_page_number,
   input  wire logic                          req_last_reference,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [scp_pkg::CFG_BITS-1:0]  csr_frames_in_use,
   output logic                               rsp_strobe,
   output logic                               rsp_hit,
   output logic [scp_pkg::IDX_OUT_BITS-1:0]   rsp_frame_index,
   output logic                               rsp_evicted_valid,
   output logic [scp_pkg::PAGE_OUT_BITS-1:0]  rsp_evicted_page,
   output logic [scp_pkg::COUNT_BITS-1:0]     rsp_fault_total,
   output logic                               rsp_run_done
);
   import scp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // frame count is latched per request, so writes are always taken
   assign csr_ready = 1'b1;

   scp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   scp_dp #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_page_number    (req_page_number),
      .req_last_reference (req_last_reference),
      .csr_we             (csr_valid && csr_ready),
      .csr_data           (csr_frames_in_use),
      .rsp_strobe         (rsp_strobe),
      .rsp_hit            (rsp_hit),
      .rsp_frame_index    (rsp_frame_index),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_page   (rsp_evicted_page),
      .rsp_fault_total    (rsp_fault_total),
      .rsp_run_done       (rsp_run_done)
   );

endmodule

`default_nettype wire

>>> src/scp_ctrl.sv
// Controller for second-chance replacement: idle, lookup, sweep, update.
// Depends on scp_pkg for state, command and status types.
`default_nettype none

module scp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  scp_pkg::sts_type       sts,
   output scp_pkg::cmd_type       cmd
);
   import scp_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = sts.match_any ? ST_UPDATE : ST_SWEEP;
         end
         ST_SWEEP: begin
            if (sts.sweep_done) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign cmd.accept = (state_ff == ST_IDLE) && start;
   assign cmd.lookup = (state_ff == ST_LOOKUP);
   assign cmd.sweep  = (state_ff == ST_SWEEP);
   assign cmd.update = (state_ff == ST_UPDATE);

endmodule

`default_nettype wire

>>> src/scp_dp.sv
// Datapath for second-chance replacement: frame tags, valid and reference
// bits, clock hand, fault counter, frame-count register and response registers.
// Depends on scp_pkg for command/status types and field widths.
`default_nettype none

module scp_dp #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  scp_pkg::cmd_type                       cmd,
   output scp_pkg::sts_type                       sts,
   input  wire logic [15:0]                       req_page_number,
   input  wire logic                              req_last_reference,
   input  wire logic                              csr_we,
   input  wire logic [scp_pkg::CFG_BITS-1:0]      csr_data,
   output logic                                   rsp_strobe,
   output logic                                   rsp_hit,
   output logic [scp_pkg::IDX_OUT_BITS-1:0]       rsp_frame_index,
   output logic                                   rsp_evicted_valid,
   output logic [scp_pkg::PAGE_OUT_BITS-1:0]      rsp_evicted_page,
   output logic [scp_pkg::COUNT_BITS-1:0]         rsp_fault_total,
   output logic                                   rsp_run_done
);
   import scp_pkg::*;

   localparam int IW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;   // frame index
   localparam int CW  = $clog2(FRAMES + 2);                  // counts up to FRAMES+1
   localparam int FB  = $clog2(FRAMES + 1);
   localparam int CFW = (FB > CFG_BITS) ? FB : CFG_BITS;     // frame-count register

   // frame state
   logic [PAGE_BITS-1:0] tag_ff [FRAMES];
   logic                 tag_we;
   logic [FRAMES-1:0]    valid_ff, valid_in;
   logic [FRAMES-1:0]    refb_ff, refb_in;
   logic [IW-1:0]        hand_ff, hand_in;
   logic [COUNT_BITS-1:0] faults_ff, faults_in;
   logic [CFW-1:0]       csr_ff;

   // per-request working registers
   logic [PAGE_BITS-1:0] page_ff;
   logic                 last_ff;
   logic [CW-1:0]        n_ff;
   logic                 found_ff;
   logic [IW-1:0]        slot_ff;
   logic [IW-1:0]        ptr_ff, ptr_in;
   logic [CW-1:0]        steps_ff, steps_in;

   // response registers
   logic                     strobe_ff;
   logic                     hit_ff;
   logic [IDX_OUT_BITS-1:0]  fidx_ff, fidx_in;
   logic                     evv_ff, evv_in;
   logic [PAGE_OUT_BITS-1:0] evp_ff, evp_in;
   logic [COUNT_BITS-1:0]    total_ff;

   logic [PAGE_BITS+15:0]    page_ext;
   logic [CFW-1:0]           n_sel;
   logic [FRAMES-1:0]        match;
   logic [IW-1:0]            match_idx;
   logic [CW-1:0]            hand_ext, ptr_ext, ptr_p1;
   logic [IW-1:0]            ptr_wrap, final_slot;
   logic [IW+IDX_OUT_BITS-1:0] slot_ext;
   logic [PAGE_BITS+PAGE_OUT_BITS-1:0] ev_ext;

   assign page_ext = {{PAGE_BITS{1'b0}}, req_page_number};

   // clamp frame count to 1..FRAMES
   always_comb begin
      if (csr_ff == '0)                n_sel = CFW'(1);
      else if (csr_ff > CFW'(FRAMES))  n_sel = CFW'(FRAMES);
      else                             n_sel = csr_ff;
   end

   // tag compare over managed frames, lowest index wins
   always_comb begin
      match_idx = '0;
      for (int j = 0; j < FRAMES; j++) begin
         match[j] = valid_ff[j] && (tag_ff[j] == page_ff) && (CW'(j) < n_ff);
      end
      for (int j = FRAMES - 1; j >= 0; j--) begin
         if (match[j]) match_idx = IW'(j);
      end
   end

   assign hand_ext = {{(CW-IW){1'b0}}, hand_ff};
   assign ptr_ext  = {{(CW-IW){1'b0}}, ptr_ff};
   assign ptr_p1   = ptr_ext + CW'(1);
   assign ptr_wrap = (ptr_p1 >= n_ff) ? '0 : ptr_p1[IW-1:0];

   assign sts.match_any  = |match;
   assign sts.sweep_done = !(refb_ff[ptr_ff] && (steps_ff <= n_ff));

   assign final_slot = found_ff ? slot_ff : ptr_ff;
   assign slot_ext   = {{IDX_OUT_BITS{1'b0}}, final_slot};
   assign ev_ext     = {{PAGE_OUT_BITS{1'b0}}, tag_ff[ptr_ff]};

   always_comb begin
      valid_in  = valid_ff;
      refb_in   = refb_ff;
      hand_in   = hand_ff;
      faults_in = faults_ff;
      ptr_in    = ptr_ff;
      steps_in  = steps_ff;
      tag_we    = 1'b0;
      fidx_in   = slot_ext[IDX_OUT_BITS-1:0];
      evv_in    = 1'b0;
      evp_in    = '0;

      if (cmd.lookup) begin
         ptr_in   = (hand_ext >= n_ff) ? '0 : hand_ff;
         steps_in = '0;
      end

      if (cmd.sweep && !sts.sweep_done) begin
         refb_in[ptr_ff] = 1'b0;
         ptr_in          = ptr_wrap;
         steps_in        = steps_ff + CW'(1);
      end

      if (cmd.update) begin
         if (found_ff) begin
            refb_in[slot_ff] = 1'b1;
         end else begin
            evv_in          = valid_ff[ptr_ff];
            evp_in          = valid_ff[ptr_ff] ? ev_ext[PAGE_OUT_BITS-1:0] : '0;
            tag_we          = 1'b1;
            valid_in[ptr_ff] = 1'b1;
            refb_in[ptr_ff]  = 1'b1;
            hand_in         = ptr_wrap;
            if (faults_ff != '1) faults_in = faults_ff + COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tag_we) tag_ff[ptr_ff] <= page_ff;
      if (cmd.accept) begin
         page_ff <= page_ext[PAGE_BITS-1:0];
         last_ff <= req_last_reference;
         n_ff    <= CW'(n_sel);
      end
      if (cmd.lookup) begin
         found_ff <= sts.match_any;
         slot_ff  <= match_idx;
      end
      ptr_ff   <= ptr_in;
      steps_ff <= steps_in;
      if (cmd.update) begin
         hit_ff   <= found_ff;
         fidx_ff  <= fidx_in;
         evv_ff   <= evv_in;
         evp_ff   <= evp_in;
         total_ff <= faults_in;
      end
   end

   // control state; a finished run clears after its response is loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         refb_ff   <= '0;
         hand_ff   <= '0;
         faults_ff <= '0;
         csr_ff    <= CFW'(FRAMES);
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.update;
         if (csr_we) csr_ff <= {{(CFW-CFG_BITS){1'b0}}, csr_data};
         if (cmd.update && last_ff) begin
            valid_ff  <= '0;
            refb_ff   <= '0;
            hand_ff   <= '0;
            faults_ff <= '0;
         end else begin
            valid_ff  <= valid_in;
            refb_ff   <= refb_in;
            hand_ff   <= hand_in;
            faults_ff <= faults_in;
         end
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_frame_index   = fidx_ff;
   assign rsp_evicted_valid = evv_ff;
   assign rsp_evicted_page  = evp_ff;
   assign rsp_fault_total   = total_ff;
   assign rsp_run_done      = last_ff;

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> !(hit_ff && evv_ff))
      else $error("hit reported an eviction");

   a_fault_counts: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && !hit_ff) |-> (total_ff != '0))
      else $error("fault with zero fault total");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> (steps_ff <= n_ff + CW'(1)))
      else $error("hand sweep overran frame count");

   a_run_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && last_ff) |=> (valid_ff == '0 && refb_ff == '0 && faults_ff == '0))
      else $error("run state not cleared after last request");

endmodule

`default_nettype wire
